// ===== hw/rtl/cle_pkg.sv =====
package cle_pkg;

  // Control characters and echo bytes.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_SP = 8'h20;

  // Prompt "=> ".
  localparam logic [7:0] PROMPT_0 = 8'h3D;
  localparam logic [7:0] PROMPT_1 = 8'h3E;
  localparam logic [7:0] PROMPT_2 = 8'h20;

  // Result kinds.
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // Command classes produced by the front end.
  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_BS   = 2'd1;
  localparam logic [1:0] CMD_CR   = 2'd2;

  // Entries in the command queue between front and back.
  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } cmd_t;

endpackage

// ===== hw/rtl/console_line_editor_core.sv =====
// Line editor for a serial console.
// Input side: each beat is one received character on rx_char, taken when
// push is high and full is low. A two-entry command queue sits behind the
// input, so a few characters can arrive while a long line is still going out.
// Result side: the oldest result sits on out_kind, out_byte, line_end and last
// while empty is low; it is taken when pop is high. out_kind tells an echo
// byte for the terminal from a line byte for the command handler, line_end
// marks the final byte of a handed-over line, and last marks the final result
// of one character.
// Flow: an accepted character passes through the command queue, and when the
// sequencer is idle it makes the first result in the result register. The
// sequencer then issues one result per cycle while pop is held high; a stored
// character gives one result, a backspace on a non-empty line three, and a
// carriage return five plus one per stored byte (at most LINE_DEPTH + 4 results).
// Characters that cause no result (a dropped character on a full line, a
// backspace on an empty line) are still taken from the queue by the sequencer.
// When the receiver stalls, the result register holds its beat and the
// sequencer waits; the command queue fills and then full rises.
// Reset clears the fill count, the queue and the result valid flag; the line
// store itself is not cleared, since only written entries are ever read.
module console_line_editor_core
  import cle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] rx_char,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       line_end,
  output logic       last
);

  // Classified characters travel from the front end to the sequencer.
  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  cle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_char  (rx_char),
    .full     (full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  cle_back #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .empty    (empty),
    .pop      (pop),
    .out_kind (out_kind),
    .out_byte (out_byte),
    .line_end (line_end),
    .last     (last)
  );

endmodule

// ===== hw/rtl/cle_front.sv =====
module cle_front
  import cle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] rx_char,
  output logic       full,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNTW = $clog2(CMDQ_DEPTH + 1);

  cmd_t            q [CMDQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  cmd_t            cmd_in;
  logic            do_push;
  logic            do_pop;

  // Sort the received character into its command class.
  always_comb begin
    cmd_in.ch = rx_char;
    if (rx_char == CH_CR) begin
      cmd_in.kind = CMD_CR;
    end else if (rx_char == CH_BS) begin
      cmd_in.kind = CMD_BS;
    end else begin
      cmd_in.kind = CMD_CHAR;
    end
  end

  assign full      = (count == CNTW'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/cle_back.sv =====
module cle_back
  import cle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  output logic       empty,
  input  logic       pop,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       line_end,
  output logic       last
);

  localparam int CW = $clog2(LINE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LF   = 4'd1;
  localparam logic [3:0] S_LINE = 4'd2;
  localparam logic [3:0] S_P0   = 4'd3;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_P2   = 4'd5;
  localparam logic [3:0] S_BS1  = 4'd6;
  localparam logic [3:0] S_BS2  = 4'd7;

  logic [7:0]    mem [LINE_DEPTH];
  logic [7:0]    rd_data;
  logic [3:0]    state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] idx, idx_next;
  logic          out_valid;
  logic          slot_free;

  logic          emit;
  logic          e_kind;
  logic [7:0]    e_byte;
  logic          e_end;
  logic          e_last;
  logic          wr_en;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic          at_end;

  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign at_end    = ((idx + 1'b1) == fill);

  always_comb begin
    state_next = state;
    fill_next  = fill;
    idx_next   = idx;
    emit       = 1'b0;
    e_kind     = KIND_ECHO;
    e_byte     = CH_CR;
    e_end      = 1'b0;
    e_last     = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    cmd_take   = 1'b0;
    if (slot_free) begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_take = 1'b1;
            unique case (cmd.kind)
              CMD_CR: begin
                emit       = 1'b1;
                e_byte     = CH_CR;
                state_next = S_LF;
              end
              CMD_BS: begin
                if (fill != '0) begin
                  emit       = 1'b1;
                  e_byte     = CH_BS;
                  fill_next  = fill - 1'b1;
                  state_next = S_BS1;
                end
              end
              CMD_CHAR: begin
                if (fill < CW'(LINE_DEPTH - 1)) begin
                  emit      = 1'b1;
                  e_byte    = cmd.ch;
                  e_last    = 1'b1;
                  wr_en     = 1'b1;
                  fill_next = fill + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LF: begin
          emit     = 1'b1;
          e_byte   = CH_LF;
          idx_next = '0;
          if (fill == '0) begin
            state_next = S_P0;
          end else begin
            // Fetch the first stored byte so it is ready in the next state.
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = S_LINE;
          end
        end
        S_LINE: begin
          emit   = 1'b1;
          e_kind = KIND_LINE;
          e_byte = rd_data;
          e_end  = at_end;
          if (at_end) begin
            state_next = S_P0;
          end else begin
            idx_next = idx + 1'b1;
            rd_en    = 1'b1;
            rd_addr  = idx + 1'b1;
          end
        end
        S_P0: begin
          emit       = 1'b1;
          e_byte     = PROMPT_0;
          state_next = S_P1;
        end
        S_P1: begin
          emit       = 1'b1;
          e_byte     = PROMPT_1;
          state_next = S_P2;
        end
        S_P2: begin
          emit       = 1'b1;
          e_byte     = PROMPT_2;
          e_last     = 1'b1;
          fill_next  = '0;
          state_next = S_IDLE;
        end
        S_BS1: begin
          emit       = 1'b1;
          e_byte     = CH_SP;
          state_next = S_BS2;
        end
        S_BS2: begin
          emit       = 1'b1;
          e_byte     = CH_BS;
          e_last     = 1'b1;
          state_next = S_IDLE;
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  // Line store: one write port at the fill position, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill] <= cmd.ch;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= e_kind;
      out_byte <= e_byte;
      line_end <= e_end;
      last     <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      idx   <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for console_line_editor_core. Received characters go in
// on the push side and every echo or line beat that comes out on the pop side
// is checked against a local model of the line editor.
module tb;
  import cle_pkg::*;

  localparam int LINE_DEPTH = 32;

  // One beat as it appears on the result ports.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       line_end;
    logic       last;
  } console_beat_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic [7:0] rx_char;
  logic       full;
  logic       empty;
  logic       pop;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       line_end;
  logic       last;

  // Characters still to be typed, and the beats the editor owes us, oldest first.
  logic [7:0]    rx_backlog[$];
  console_beat_t console_bytes_q[$];

  // Local copy of the edit line.
  logic [7:0] line_copy[LINE_DEPTH];
  int         line_fill;

  // Idle percentages for each side; they change from phase to phase.
  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;

  console_beat_t got_beat;
  console_beat_t want_beat;

  console_line_editor_core #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_char  (rx_char),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_kind (out_kind),
    .out_byte (out_byte),
    .line_end (line_end),
    .last     (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic console_beat_t make_beat(input logic kind, input logic [7:0] data,
                                              input logic is_end);
    console_beat_t b;
    b.kind     = kind;
    b.data     = data;
    b.line_end = is_end;
    b.last     = 1'b0;
    return b;
  endfunction

  // Applies one received character to the local line and queues the beats it
  // causes. The final beat of the character carries last.
  function automatic void edit_line(input logic [7:0] c);
    console_beat_t burst[$];
    console_beat_t b;
    if (c == CH_CR) begin
      burst.push_back(make_beat(KIND_ECHO, CH_CR, 1'b0));
      burst.push_back(make_beat(KIND_ECHO, CH_LF, 1'b0));
      for (int i = 0; i < line_fill; i++)
        burst.push_back(make_beat(KIND_LINE, line_copy[i], i + 1 == line_fill));
      burst.push_back(make_beat(KIND_ECHO, PROMPT_0, 1'b0));
      burst.push_back(make_beat(KIND_ECHO, PROMPT_1, 1'b0));
      burst.push_back(make_beat(KIND_ECHO, PROMPT_2, 1'b0));
      line_fill = 0;
    end else if (c == CH_BS) begin
      // Rubout on an empty line is silent.
      if (line_fill != 0) begin
        line_fill = line_fill - 1;
        burst.push_back(make_beat(KIND_ECHO, CH_BS, 1'b0));
        burst.push_back(make_beat(KIND_ECHO, CH_SP, 1'b0));
        burst.push_back(make_beat(KIND_ECHO, CH_BS, 1'b0));
      end
    end else if (line_fill < LINE_DEPTH - 1) begin
      // Any other byte, zero included, is stored and echoed while room
      // remains; on a full line it is dropped with no echo.
      line_copy[line_fill] = c;
      line_fill = line_fill + 1;
      burst.push_back(make_beat(KIND_ECHO, c, 1'b0));
    end
    for (int i = 0; i < burst.size(); i++) begin
      b = burst[i];
      b.last = (i == burst.size() - 1);
      console_bytes_q.push_back(b);
    end
  endfunction

  // A random byte that is neither carriage return nor backspace.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_CR || c == CH_BS)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Appends one random typing session to the backlog. Most sessions are
  // complete lines ended by a carriage return, so the editor gets to hand
  // over lines of many lengths; a few overrun the line, a few rub out at least
  // as much as they typed, and the rest are raw noise.
  task automatic queue_session();
    int pick;
    int len;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        rx_backlog.push_back(plain_char());
        if ($urandom_range(0, 99) < 15)
          rx_backlog.push_back(CH_BS);
      end
      rx_backlog.push_back(CH_CR);
    end else if (pick <= 7) begin
      // Run the line up to its limit and past it, so that some bytes drop.
      len = $urandom_range(LINE_DEPTH - 2, LINE_DEPTH + 3);
      for (int i = 0; i < len; i++)
        rx_backlog.push_back(plain_char());
      if ($urandom_range(0, 1) == 1) begin
        rx_backlog.push_back(CH_BS);
        rx_backlog.push_back(plain_char());
        rx_backlog.push_back(plain_char());
      end
      rx_backlog.push_back(CH_CR);
    end else if (pick == 8) begin
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++)
        rx_backlog.push_back(plain_char());
      len = len + $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        rx_backlog.push_back(CH_BS);
      rx_backlog.push_back(CH_CR);
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: rx_backlog.push_back(CH_CR);
          1: rx_backlog.push_back(CH_BS);
          default: rx_backlog.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // Driver. A beat is taken at an edge where push is high and full is low;
  // until then the current character is held. After a taken beat the next
  // character goes out right away unless the sender idles this cycle.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        edit_line(rx_char);
        void'(rx_backlog.pop_front());
      end
      if (!push || !full) begin
        if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          push    <= 1'b1;
          rx_char <= rx_backlog[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every beat taken off the result side is matched against the
  // oldest beat the model expects; pop is dropped at random to stall it.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got_beat = '{kind: out_kind, data: out_byte, line_end: line_end, last: last};
        if (console_bytes_q.size() == 0) begin
          $error("unexpected beat: kind %0d byte 0x%02h line_end %0d last %0d",
                 out_kind, out_byte, line_end, last);
          mismatch_count++;
        end else begin
          want_beat = console_bytes_q.pop_front();
          if (got_beat.kind !== want_beat.kind) begin
            $error("out_kind: expected %0d, actual %0d", want_beat.kind, got_beat.kind);
            mismatch_count++;
          end
          if (got_beat.data !== want_beat.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want_beat.data,
                   got_beat.data);
            mismatch_count++;
          end
          if (got_beat.line_end !== want_beat.line_end) begin
            $error("line_end: expected %0d, actual %0d", want_beat.line_end,
                   got_beat.line_end);
            mismatch_count++;
          end
          if (got_beat.last !== want_beat.last) begin
            $error("last: expected %0d, actual %0d", want_beat.last, got_beat.last);
            mismatch_count++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus. Three phases, each filled in one go and then drained fully
  // before the next, so the sender also sits still until every owed beat has
  // come. The idle mix changes per phase: a slow receiver first, then a slow
  // sender, then both sides at full rate.
  initial begin
    int base;
    rst            = 1'b1;
    push           = 1'b0;
    pop            = 1'b0;
    rx_char        = 8'h00;
    line_fill      = 0;
    mismatch_count = 0;
    send_idle_pct  = 22;
    recv_idle_pct  = 60;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // Carriage return and rubout on an empty line come first.
        rx_backlog.push_back(CH_CR);
        rx_backlog.push_back(CH_BS);
        // Zero, all ones and other edge bytes are ordinary characters.
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(8'h0A);
        rx_backlog.push_back(8'h7F);
        rx_backlog.push_back(8'h80);
        rx_backlog.push_back(CH_BS);
        rx_backlog.push_back(CH_CR);
        rx_backlog.push_back(8'h01);
        rx_backlog.push_back(CH_BS);
        rx_backlog.push_back(CH_BS);
        rx_backlog.push_back(CH_BS);
        rx_backlog.push_back(8'h55);
        rx_backlog.push_back(8'hAA);
        rx_backlog.push_back(8'hFE);
        rx_backlog.push_back(8'h09);
        rx_backlog.push_back(8'h0C);
        rx_backlog.push_back(CH_CR);
        rx_backlog.push_back(8'h20);
        rx_backlog.push_back(CH_CR);
      end

      base = rx_backlog.size();
      while (rx_backlog.size() - base < 66)
        queue_session();

      while (rx_backlog.size() != 0 || push || console_bytes_q.size() != 0)
        @(negedge clk);
      // Dropped characters and silent rubouts cause no beat, so the bench waits on
      // past the last owed beat for the sequencer to take them.
      repeat (8) @(negedge clk);
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
